[hdl/kscd_pkg.sv]
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types, codes and character tables of the keyboard scan code decoder.
// ----------------------------------------------------------------------------
package kscd_pkg;

  localparam int unsigned CMD_QUEUE_DEPTH_DEF = 32;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_FOCUS = 2'd2
  } kind_e;

  // scan codes, set 1
  localparam logic [7:0] SC_BKSP     = 8'h0E;
  localparam logic [7:0] SC_TAB      = 8'h0F;
  localparam logic [7:0] SC_ENTER    = 8'h1C;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_LSHIFT_R = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_R = 8'hB6;
  localparam logic [7:0] SC_CAPS     = 8'h3A;
  localparam logic [7:0] SC_NUM      = 8'h45;
  localparam logic [7:0] SC_SCROLL   = 8'h46;

  // keyboard responses and commands
  localparam logic [7:0] RSP_ACK     = 8'hFA;
  localparam logic [7:0] RSP_RESEND  = 8'hFE;
  localparam logic [7:0] CMD_LED     = 8'hED;

  // character codes
  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // led bit masks
  localparam logic [2:0] LED_SCROLL  = 3'b001;
  localparam logic [2:0] LED_NUM     = 3'b010;
  localparam logic [2:0] LED_CAPS    = 3'b100;

  typedef struct packed {
    logic       r0_valid;
    kind_e      r0_kind;
    logic [7:0] r0_value;
    logic [1:0] shift;
    logic [2:0] led;
    logic       focus;
    logic       lock;
    logic       ack;
  } dec_t;

  typedef struct packed {
    logic pop;
    logic drop;
  } q_resp_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       to_console;
    logic       ovf;
    logic       last;
  } res_t;

  function automatic logic [7:0] plain_char(input logic [6:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      7'h02: c = 8'h31;
      7'h03: c = 8'h32;
      7'h04: c = 8'h33;
      7'h05: c = 8'h34;
      7'h06: c = 8'h35;
      7'h07: c = 8'h36;
      7'h08: c = 8'h37;
      7'h09: c = 8'h38;
      7'h0A: c = 8'h39;
      7'h0B: c = 8'h30;
      7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;
      7'h10: c = 8'h51;
      7'h11: c = 8'h57;
      7'h12: c = 8'h45;
      7'h13: c = 8'h52;
      7'h14: c = 8'h54;
      7'h15: c = 8'h59;
      7'h16: c = 8'h55;
      7'h17: c = 8'h49;
      7'h18: c = 8'h4F;
      7'h19: c = 8'h50;
      7'h1A: c = 8'h5B;
      7'h1B: c = 8'h5D;
      7'h1E: c = 8'h41;
      7'h1F: c = 8'h53;
      7'h20: c = 8'h44;
      7'h21: c = 8'h46;
      7'h22: c = 8'h47;
      7'h23: c = 8'h48;
      7'h24: c = 8'h4A;
      7'h25: c = 8'h4B;
      7'h26: c = 8'h4C;
      7'h27: c = 8'h3B;
      7'h28: c = 8'h27;
      7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;
      7'h2C: c = 8'h5A;
      7'h2D: c = 8'h58;
      7'h2E: c = 8'h43;
      7'h2F: c = 8'h56;
      7'h30: c = 8'h42;
      7'h31: c = 8'h4E;
      7'h32: c = 8'h4D;
      7'h33: c = 8'h2C;
      7'h34: c = 8'h2E;
      7'h35: c = 8'h2F;
      7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      7'h47: c = 8'h37;
      7'h48: c = 8'h38;
      7'h49: c = 8'h39;
      7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34;
      7'h4C: c = 8'h35;
      7'h4D: c = 8'h36;
      7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31;
      7'h50: c = 8'h32;
      7'h51: c = 8'h33;
      7'h52: c = 8'h30;
      7'h53: c = 8'h2E;
      7'h73: c = 8'h5C;
      7'h7D: c = 8'h5C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // only the entries that differ from the plain table
  function automatic logic [7:0] shifted_char(input logic [6:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      7'h02: c = 8'h21;
      7'h03: c = 8'h40;
      7'h04: c = 8'h23;
      7'h05: c = 8'h24;
      7'h06: c = 8'h25;
      7'h07: c = 8'h5E;
      7'h08: c = 8'h26;
      7'h09: c = 8'h2A;
      7'h0A: c = 8'h28;
      7'h0B: c = 8'h29;
      7'h0C: c = 8'h5F;
      7'h0D: c = 8'h2B;
      7'h1A: c = 8'h7B;
      7'h1B: c = 8'h7D;
      7'h27: c = 8'h3A;
      7'h28: c = 8'h22;
      7'h29: c = 8'h7E;
      7'h2B: c = 8'h7C;
      7'h33: c = 8'h3C;
      7'h34: c = 8'h3E;
      7'h35: c = 8'h3F;
      7'h73: c = 8'h5F;
      7'h7D: c = 8'h7C;
      default: c = plain_char(idx);
    endcase
    return c;
  endfunction

endpackage

[hdl/kscd_decode.sv]
// ----------------------------------------------------------------------------
// kscd_decode
// Decodes one keyboard byte against the current shift, led and focus state:
// character lookup, special keys, lock keys and keyboard responses.
// ----------------------------------------------------------------------------
module kscd_decode import kscd_pkg::*; (
  input  logic [7:0] scan_byte_i,
  input  logic [1:0] shift_i,
  input  logic [2:0] led_i,
  input  logic       focus_i,
  input  logic       out_valid_i,
  input  logic [7:0] out_byte_i,
  output dec_t       dec_o
);

  logic [7:0] ch;
  logic       shifted;
  logic       caps;

  assign shifted = (shift_i != 2'b00);
  assign caps    = ((led_i & LED_CAPS) != 3'b000);

  always_comb begin
    ch = 8'h00;
    if (!scan_byte_i[7]) begin
      ch = shifted ? shifted_char(scan_byte_i[6:0]) : plain_char(scan_byte_i[6:0]);
    end
    // lower case unless caps xor shift
    if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z && caps == shifted) begin
      ch = ch + CASE_OFFSET;
    end

    dec_o.r0_valid = (ch != 8'h00);
    dec_o.r0_kind  = KIND_CHAR;
    dec_o.r0_value = ch;
    dec_o.shift    = shift_i;
    dec_o.led      = led_i;
    dec_o.focus    = focus_i;
    dec_o.lock     = 1'b0;
    dec_o.ack      = 1'b0;

    case (scan_byte_i)
      SC_BKSP: begin
        dec_o.r0_valid = 1'b1;
        dec_o.r0_value = CHAR_BS;
      end
      SC_ENTER: begin
        dec_o.r0_valid = focus_i;
        dec_o.r0_value = CHAR_LF;
      end
      SC_TAB: begin
        dec_o.focus    = ~focus_i;
        dec_o.r0_valid = 1'b1;
        dec_o.r0_kind  = KIND_FOCUS;
        dec_o.r0_value = {7'b0, ~focus_i};
      end
      SC_LSHIFT:   dec_o.shift = shift_i | 2'b01;
      SC_RSHIFT:   dec_o.shift = shift_i | 2'b10;
      SC_LSHIFT_R: dec_o.shift = shift_i & 2'b10;
      SC_RSHIFT_R: dec_o.shift = shift_i & 2'b01;
      SC_CAPS: begin
        dec_o.led  = led_i ^ LED_CAPS;
        dec_o.lock = 1'b1;
      end
      SC_NUM: begin
        dec_o.led  = led_i ^ LED_NUM;
        dec_o.lock = 1'b1;
      end
      SC_SCROLL: begin
        dec_o.led  = led_i ^ LED_SCROLL;
        dec_o.lock = 1'b1;
      end
      RSP_ACK:  dec_o.ack = 1'b1;
      RSP_RESEND: begin
        dec_o.r0_valid = out_valid_i;
        dec_o.r0_kind  = KIND_CMD;
        dec_o.r0_value = out_byte_i;
      end
      default: ;
    endcase
  end

endmodule

[hdl/kscd_cmd_queue.sv]
// ----------------------------------------------------------------------------
// kscd_cmd_queue
// Circular command byte queue in a synchronous memory. A lock key pushes the
// led command at the step and the registered led byte after it; a pop reads
// the head entry. The two bytes queued at reset are supplied by preload flags.
// ----------------------------------------------------------------------------
module kscd_cmd_queue import kscd_pkg::*; #(
  parameter int unsigned DEPTH = CMD_QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       lock_i,
  input  logic [2:0] led_i,
  input  logic       pop_req_i,
  input  logic       boot_we_i,
  input  logic [2:0] boot_led_i,
  output q_resp_t    resp_o,
  output logic [7:0] pop_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] SRC_MEM  = 2'd0;
  localparam logic [1:0] SRC_CMD  = 2'd1;
  localparam logic [1:0] SRC_BOOT = 2'd2;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_q;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, wr2_idx_q;
  logic [IDX_W-1:0] head_inc, tail_inc1, tail_inc2;
  logic [CNT_W-1:0] count_q, count_d, count_push;
  logic [7:0]       wr2_data_q;
  logic             wr2_q;
  logic [1:0]       pre_q, pre_d;
  logic [2:0]       boot_led_q;
  logic [1:0]       src_q;
  logic             push1, push2, pop;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [7:0]       wdata;

  assign head_inc  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc1 = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_inc2 = (tail_inc1 == IDX_W'(DEPTH - 1)) ? '0 : tail_inc1 + 1'b1;

  // each byte of the pair checks for room on its own
  assign push1      = lock_i && (count_q < CNT_W'(DEPTH));
  assign push2      = lock_i && (count_q < CNT_W'(DEPTH - 1));
  assign count_push = count_q + CNT_W'(push1) + CNT_W'(push2);
  assign pop        = pop_req_i && (count_push != '0);

  assign resp_o.pop  = pop;
  assign resp_o.drop = lock_i && !push2;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (step_i) begin
      count_d = count_push - CNT_W'(pop);
      if (pop) begin
        head_d = head_inc;
      end
      if (push2) begin
        tail_d = tail_inc2;
      end else if (push1) begin
        tail_d = tail_inc1;
      end
    end
  end

  // single write port: led command at the step, led byte in the cycle after
  always_comb begin
    we    = 1'b0;
    waddr = tail_q;
    wdata = CMD_LED;
    if (step_i && push1) begin
      we = 1'b1;
    end else if (wr2_q) begin
      we    = 1'b1;
      waddr = wr2_idx_q;
      wdata = wr2_data_q;
    end
  end

  always_comb begin
    pre_d = pre_q;
    if (we && waddr == IDX_W'(0)) begin
      pre_d[0] = 1'b0;
    end
    if (we && waddr == IDX_W'(1)) begin
      pre_d[1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && pop && count_q != '0) begin
      rdata_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      wr2_idx_q  <= tail_inc1;
      wr2_data_q <= {5'b0, led_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= IDX_W'(2);
      count_q    <= CNT_W'(2);
      wr2_q      <= 1'b0;
      pre_q      <= 2'b11;
      boot_led_q <= 3'b000;
      src_q      <= SRC_MEM;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      pre_q   <= pre_d;
      wr2_q   <= step_i && push2;
      if (boot_we_i) begin
        boot_led_q <= boot_led_i;
      end
      if (step_i && pop) begin
        // an empty queue pops the led command pushed in the same step
        if (count_q == '0) begin
          src_q <= SRC_CMD;
        end else if (head_q == IDX_W'(0) && pre_q[0]) begin
          src_q <= SRC_CMD;
        end else if (head_q == IDX_W'(1) && pre_q[1]) begin
          src_q <= SRC_BOOT;
        end else begin
          src_q <= SRC_MEM;
        end
      end
    end
  end

  always_comb begin
    case (src_q)
      SRC_CMD:  pop_data_o = CMD_LED;
      SRC_BOOT: pop_data_o = {5'b0, boot_led_q};
      default:  pop_data_o = rdata_q;
    endcase
  end

endmodule

[hdl/kscd_out_buf.sv]
// ----------------------------------------------------------------------------
// kscd_out_buf
// Two-entry result buffer; takes up to two results in one cycle and hands
// them out one per transaction.
// ----------------------------------------------------------------------------
module kscd_out_buf import kscd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  res_t       wr_a_i,
  input  res_t       wr_b_i,
  output logic [1:0] free_o,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output res_t       rd_data_o
);

  res_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       rd;

  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = ent_q[rd_q];
  // an entry leaving this cycle counts as free
  assign free_o     = 2'd2 - cnt_q + 2'(rd);

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      ent_q[wr_q] <= wr_a_i;
    end
    if (wr_cnt_i == 2'd2) begin
      ent_q[~wr_q] <= wr_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_q ^ wr_cnt_i[0];
      rd_q  <= rd_q ^ rd;
      cnt_q <= cnt_q + wr_cnt_i - 2'(rd);
    end
  end

endmodule

[hdl/keyboard_scancode_decoder.sv]
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder
// Scan code set 1 keyboard byte decoder with shift, lock led and focus
// tracking and a command byte queue toward the keyboard.
// ----------------------------------------------------------------------------
// results of a byte pass from the s1 result stage registers into the output buffer
// a new byte is taken only once the previous one has left the result stage;
//   the queue memory takes the led command and led byte through one write port
// up to two results per byte leave through a two-entry output buffer
// reset: asynchronous; the queue holds the led command and led byte at once,
//   no memory clearing pass is needed
module keyboard_scancode_decoder import kscd_pkg::*; #(
  parameter int unsigned CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value, [8] to_console, [9] queue_overflow
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  dec_t       dec;
  q_resp_t    qresp;
  res_t       res_a, res_b, rd_res;
  logic [7:0] pop_data;
  logic       accept, cfg_we, out_av_dec, ovf_eff, drain;
  logic [1:0] need, free, wr_cnt;

  logic [1:0] shift_q;
  logic [2:0] led_q;
  logic       focus_q, out_valid_q, drop_q, fresh_q;
  logic [7:0] out_byte_q;

  logic       s1_valid_q, s1_new_q, s1_r0v_q, s1_pop_q, s1_focus_q, s1_ovf_q;
  kind_e      s1_kind_q;
  logic [7:0] s1_val_q;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !s1_valid_q;
  assign cfg_ready_o   = 1'b1;
  // led state follows the register only until the first byte
  assign cfg_we        = cfg_valid_i && fresh_q;

  kscd_decode u_decode (
    .scan_byte_i (s_axis_tdata),
    .shift_i     (shift_q),
    .led_i       (led_q),
    .focus_i     (focus_q),
    .out_valid_i (out_valid_q),
    .out_byte_i  (out_byte_q),
    .dec_o       (dec)
  );

  assign out_av_dec = dec.ack ? 1'b0 : out_valid_q;

  kscd_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .lock_i     (dec.lock),
    .led_i      (dec.led),
    .pop_req_i  (!out_av_dec),
    .boot_we_i  (cfg_we),
    .boot_led_i (cfg_data_i),
    .resp_o     (qresp),
    .pop_data_o (pop_data)
  );

  assign ovf_eff = drop_q || qresp.drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 2'b00;
      led_q       <= 3'b000;
      focus_q     <= 1'b0;
      out_valid_q <= 1'b0;
      drop_q      <= 1'b0;
      fresh_q     <= 1'b1;
    end else begin
      if (accept) begin
        shift_q     <= dec.shift;
        led_q       <= dec.led;
        focus_q     <= dec.focus;
        out_valid_q <= out_av_dec || qresp.pop;
        drop_q      <= (dec.r0_valid || qresp.pop) ? 1'b0 : ovf_eff;
        fresh_q     <= 1'b0;
      end else if (cfg_we) begin
        led_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_new_q && s1_pop_q) begin
      out_byte_q <= pop_data;
    end
  end

  // result stage
  assign need   = 2'(s1_r0v_q) + 2'(s1_pop_q);
  assign drain  = s1_valid_q && (need <= free);
  assign wr_cnt = drain ? need : 2'd0;

  always_comb begin
    res_a.kind       = s1_r0v_q ? s1_kind_q : KIND_CMD;
    res_a.value      = s1_r0v_q ? s1_val_q : pop_data;
    res_a.to_console = s1_focus_q;
    res_a.ovf        = s1_ovf_q;
    res_a.last       = !(s1_r0v_q && s1_pop_q);
    res_b.kind       = KIND_CMD;
    res_b.value      = pop_data;
    res_b.to_console = s1_focus_q;
    res_b.ovf        = s1_ovf_q;
    res_b.last       = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_r0v_q   <= dec.r0_valid;
      s1_kind_q  <= dec.r0_kind;
      s1_val_q   <= dec.r0_value;
      s1_pop_q   <= qresp.pop;
      s1_focus_q <= dec.focus;
      s1_ovf_q   <= ovf_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_new_q   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_new_q   <= 1'b1;
      end else begin
        s1_new_q <= 1'b0;
        if (drain) begin
          s1_valid_q <= 1'b0;
        end
      end
    end
  end

  kscd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (wr_cnt),
    .wr_a_i     (res_a),
    .wr_b_i     (res_b),
    .free_o     (free),
    .rd_valid_o (m_axis_tvalid),
    .rd_ready_i (m_axis_tready),
    .rd_data_o  (rd_res)
  );

  assign m_axis_tdata = {6'b0, rd_res.ovf, rd_res.to_console, rd_res.value};
  assign m_axis_tuser = rd_res.kind;
  assign m_axis_tlast = rd_res.last;

`ifndef SYNTH
  // a pending pop result implies a byte is outstanding toward the keyboard
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_pop_q |-> out_valid_q)
    else $error("pop result without outstanding byte");

  // a focus change reports the new focus in both fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_FOCUS |->
      m_axis_tdata[8] == m_axis_tdata[0] && m_axis_tdata[7:1] == 7'b0)
    else $error("focus result inconsistent");

  // bytes are never taken back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !accept)
    else $error("back to back transactions on input");
`endif

endmodule

[test/keyboard_scancode_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_test
// Self-checking bench for the scan code decoder. A short table of keyboard
// bytes covers reset, acknowledge and resend, shift, lock, focus and the
// special codes. Random typing, lock bursts and noise follow. Every result
// leaving the block is checked against a table row or a copy of the decoder.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder_test;
  import kscd_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = CMD_QUEUE_DEPTH_DEF;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 155;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MAX_REPORTS   = 10;
  localparam int          CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [7:0] sb;
    bit         typed;
    int         n;
    res_t       r0;
    res_t       r1;
  } stim_row_t;

  localparam res_t NO_RESULT = '0;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;   // [7:0] value, [8] to_console, [9] queue_overflow
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i    = 3'd0;

  keyboard_scancode_decoder #(
    .CMD_QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // character tables of scan code set 1
  logic [7:0] plain_keys [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
  };

  logic [7:0] shifted_keys [128] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
  };

  logic [7:0] shift_codes [4] = '{SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_R, SC_RSHIFT_R};
  logic [7:0] lock_codes  [3] = '{SC_CAPS, SC_NUM, SC_SCROLL};
  logic [7:0] edit_codes  [3] = '{SC_TAB, SC_ENTER, SC_BKSP};

  // decoder copy
  logic [1:0] shift_state   = 2'b00;
  logic [2:0] led_state     = 3'd0;
  logic       focus_console = 1'b0;
  logic [7:0] cmd_fifo [$];
  logic       pending_valid = 1'b0;
  logic [7:0] pending_byte  = 8'h00;
  logic       dropped       = 1'b0;
  logic       untouched     = 1'b1;

  res_t      step_results [$];
  res_t      expected_results [$];
  stim_row_t stim_rows [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_run         = 0;
  int rx_run         = 0;
  int rx_wait        = 0;

  // random wait per item, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run_left = 25;
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic res_t mk(input kind_e kd, input logic [7:0] v, input logic con,
                              input logic ovf, input logic lst);
    res_t r;
    r.kind       = kd;
    r.value      = v;
    r.to_console = con;
    r.ovf        = ovf;
    r.last       = lst;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] sb, input bit typed, input int n,
                         input res_t r0, input res_t r1);
    stim_row_t row;
    row.sb    = sb;
    row.typed = typed;
    row.n     = n;
    row.r0    = r0;
    row.r1    = r1;
    stim_rows.push_back(row);
  endtask

  task automatic add_result(input kind_e kd, input logic [7:0] v);
    step_results.push_back(mk(kd, v, focus_console, 1'b0, 1'b0));
  endtask

  task automatic push_cmd(input logic [7:0] b);
    if (cmd_fifo.size() >= QUEUE_DEPTH) dropped = 1'b1;
    else cmd_fifo.push_back(b);
  endtask

  task automatic reset_decoder();
    shift_state   = 2'b00;
    led_state     = 3'd0;
    focus_console = 1'b0;
    cmd_fifo.delete();
    cmd_fifo.push_back(CMD_LED);
    cmd_fifo.push_back(8'h00);
    pending_valid = 1'b0;
    dropped       = 1'b0;
    untouched     = 1'b1;
  endtask

  // results caused by one keyboard byte, left in step_results
  task automatic decode_byte(input logic [7:0] sb);
    logic [7:0] ch;
    res_t       tmp;
    int         k;
    step_results.delete();
    untouched = 1'b0;
    ch = 8'h00;
    if (!sb[7]) ch = (shift_state != 2'b00) ? shifted_keys[sb[6:0]] : plain_keys[sb[6:0]];
    if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
      if (((led_state & LED_CAPS) != 3'd0) == (shift_state != 2'b00)) ch = ch + CASE_OFFSET;
    end
    if (ch != 8'h00) add_result(KIND_CHAR, ch);
    case (sb)
      SC_BKSP:     add_result(KIND_CHAR, CHAR_BS);
      SC_ENTER:    if (focus_console) add_result(KIND_CHAR, CHAR_LF);
      SC_TAB: begin
        focus_console = ~focus_console;
        add_result(KIND_FOCUS, {7'd0, focus_console});
      end
      SC_LSHIFT:   shift_state[0] = 1'b1;
      SC_RSHIFT:   shift_state[1] = 1'b1;
      SC_LSHIFT_R: shift_state[0] = 1'b0;
      SC_RSHIFT_R: shift_state[1] = 1'b0;
      SC_CAPS, SC_NUM, SC_SCROLL: begin
        led_state = led_state ^ ((sb == SC_CAPS) ? LED_CAPS :
                                 (sb == SC_NUM)  ? LED_NUM  : LED_SCROLL);
        push_cmd(CMD_LED);
        push_cmd({5'd0, led_state});
      end
      RSP_ACK:     pending_valid = 1'b0;
      RSP_RESEND:  if (pending_valid) add_result(KIND_CMD, pending_byte);
      default: ;
    endcase
    if (!pending_valid && cmd_fifo.size() > 0) begin
      pending_byte  = cmd_fifo.pop_front();
      pending_valid = 1'b1;
      add_result(KIND_CMD, pending_byte);
    end
    for (k = 0; k < step_results.size(); k++) begin
      tmp = step_results[k];
      tmp.ovf  = dropped;
      tmp.last = (k == step_results.size() - 1);
      step_results[k] = tmp;
    end
    if (step_results.size() > 0) dropped = 1'b0;
  endtask

  task automatic write_leds(input logic [2:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    // only writes before the first byte reach the led state and queued led byte
    if (untouched) begin
      led_state   = v;
      cmd_fifo[1] = {5'd0, v};
    end
  endtask

  // returns in the time step of the accepting edge, valid still high
  task automatic send_byte(input logic [7:0] sb);
    int gap;
    gap = draw_wait(tx_run);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= sb;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic feed_byte(input logic [7:0] sb);
    send_byte(sb);
    decode_byte(sb);
    foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // bytes with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    logic [7:0] sb;
    int         choice;
    int         done;
    int         j;
    done = 0;
    while (done < count) begin
      choice = $urandom_range(0, 99);
      if (choice == 99) begin
        // lock keys with no acknowledge in between overrun the command queue
        for (j = 0; j < 18; j++) feed_byte(lock_codes[$urandom_range(0, 2)]);
        done += 18;
      end else begin
        if (choice < 40)      sb = 8'($urandom_range(0, 127));
        else if (choice < 50) sb = shift_codes[$urandom_range(0, 3)];
        else if (choice < 55) sb = lock_codes[$urandom_range(0, 2)];
        else if (choice < 60) sb = edit_codes[$urandom_range(0, 2)];
        else if (choice < 80) sb = RSP_ACK;
        else if (choice < 85) sb = RSP_RESEND;
        else                  sb = 8'($urandom_range(0, 255));
        if (!((sb == RSP_ACK || sb == RSP_RESEND) && !pending_valid)) done++;
        feed_byte(sb);
      end
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.kind       = kind_e'(m_axis_tuser);
    got.value      = m_axis_tdata[7:0];
    got.to_console = m_axis_tdata[8];
    got.ovf        = m_axis_tdata[9];
    got.last       = m_axis_tlast;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result: kind %0d value %h con %b ovf %b last %b",
                 got.kind, got.value, got.to_console, got.ovf, got.last);
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result mismatch: want kind %0d value %h con %b ovf %b last %b, %s",
                   want.kind, want.value, want.to_console, want.ovf, want.last,
                   $sformatf("got kind %0d value %h con %b ovf %b last %b",
                             got.kind, got.value, got.to_console, got.ovf, got.last));
      end
    end
  endtask

  // result side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_result();
      rx_wait = draw_wait(rx_run);
      m_axis_tready <= (rx_wait == 0);
    end else if (!m_axis_tready) begin
      if (rx_wait > 0) rx_wait--;
      else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        p;

    // led byte 7 after reset is set by the second register write below
    add_row(8'h00,       1, 1, mk(KIND_CMD, CMD_LED, 1'b0, 1'b0, 1'b1), NO_RESULT);
    add_row(RSP_ACK,     1, 1, mk(KIND_CMD, 8'h07, 1'b0, 1'b0, 1'b1), NO_RESULT);
    add_row(RSP_RESEND,  1, 1, mk(KIND_CMD, 8'h07, 1'b0, 1'b0, 1'b1), NO_RESULT);
    add_row(RSP_ACK,     1, 0, NO_RESULT, NO_RESULT);
    add_row(RSP_ACK,     1, 0, NO_RESULT, NO_RESULT);
    add_row(RSP_RESEND,  1, 0, NO_RESULT, NO_RESULT);
    add_row(8'h1E,       0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_LSHIFT,   0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h1E,       0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h02,       0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h7D,       0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_LSHIFT_R, 0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_BKSP,     1, 1, mk(KIND_CHAR, CHAR_BS, 1'b0, 1'b0, 1'b1), NO_RESULT);
    add_row(SC_ENTER,    1, 0, NO_RESULT, NO_RESULT);
    add_row(SC_TAB,      1, 1, mk(KIND_FOCUS, 8'h01, 1'b1, 1'b0, 1'b1), NO_RESULT);
    add_row(SC_ENTER,    1, 1, mk(KIND_CHAR, CHAR_LF, 1'b1, 1'b0, 1'b1), NO_RESULT);
    add_row(SC_RSHIFT,   0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h7F,       0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h73,       0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_RSHIFT_R, 0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_CAPS,     0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h10,       0, 0, NO_RESULT, NO_RESULT);
    add_row(RSP_ACK,     0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_NUM,      0, 0, NO_RESULT, NO_RESULT);
    add_row(SC_SCROLL,   0, 0, NO_RESULT, NO_RESULT);
    add_row(8'hFF,       0, 0, NO_RESULT, NO_RESULT);
    add_row(8'h80,       0, 0, NO_RESULT, NO_RESULT);

    reset_decoder();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_leds(3'd0);
    write_leds(3'd7);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_byte(row.sb);
      decode_byte(row.sb);
      if (row.typed) begin
        if (row.n > 0) expected_results.push_back(row.r0);
        if (row.n > 1) expected_results.push_back(row.r1);
      end else begin
        foreach (step_results[k]) expected_results.push_back(step_results[k]);
      end
    end
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      write_leds((p == 0) ? 3'd0 : (p == 1) ? 3'd7 : 3'($urandom_range(0, 7)));
      random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[keyboard_scancode_decoder.f]
hdl/kscd_pkg.sv
hdl/kscd_decode.sv
hdl/kscd_cmd_queue.sv
hdl/kscd_out_buf.sv
hdl/keyboard_scancode_decoder.sv
test/keyboard_scancode_decoder_test.sv
